@@ rtl/tri_pkg.sv @@
package tri_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int ANGLE_FRAC_DEF  = 16;
  localparam int CORDIC_STEPS    = 30;
  localparam int SQRT_STEPS      = 32;
  localparam int DIV_STEPS       = 30;
  localparam int CFG_IDX_W       = 3;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AX = 3'd0, REG_AY = 3'd1, REG_AZ = 3'd2,
    REG_BX = 3'd3, REG_BY = 3'd4, REG_BZ = 3'd5
  } cfg_reg_t;

  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] v;
    case (i)
      0: v = 31'd843314856;   1: v = 31'd497837829;   2: v = 31'd263043836;
      3: v = 31'd133525158;   4: v = 31'd67021686;    5: v = 31'd33543515;
      6: v = 31'd16775850;    7: v = 31'd8388437;     8: v = 31'd4194282;
      9: v = 31'd2097149;     10: v = 31'd1048575;    11: v = 31'd524287;
      12: v = 31'd262143;     13: v = 31'd131071;     14: v = 31'd65535;
      15: v = 31'd32767;      16: v = 31'd16383;      17: v = 31'd8191;
      18: v = 31'd4095;       19: v = 31'd2047;       20: v = 31'd1023;
      21: v = 31'd511;        22: v = 31'd255;        23: v = 31'd127;
      24: v = 31'd63;         25: v = 31'd31;         26: v = 31'd15;
      27: v = 31'd8;          28: v = 31'd4;          29: v = 31'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/tri_sqrt_stage.sv @@
// One restoring step of an integer square root on a 64-bit radicand.
module tri_sqrt_stage #(
  parameter int STEP = 0
) (
  input  logic        clk,
  input  logic [63:0] rem_in,
  input  logic [63:0] res_in,
  output logic [63:0] rem_out,
  output logic [63:0] res_out
);
  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);
  logic [63:0] trial;
  assign trial = res_in + BIT;
  always_ff @(posedge clk) begin
    if (rem_in >= trial) begin
      rem_out <= rem_in - trial;
      res_out <= (res_in >> 1) + BIT;
    end else begin
      rem_out <= rem_in;
      res_out <= res_in >> 1;
    end
  end
endmodule

@@ rtl/tri_cordic.sv @@
// Pipelined vectoring CORDIC, one micro-rotation per stage, Q.30 angle out.
module tri_cordic (
  input  logic        clk,
  input  logic        vin,
  input  logic [31:0] x_in,
  input  logic [31:0] y_in,
  input  logic        deg_in,
  output logic        vout,
  output logic [31:0] z_out,
  output logic        deg_out
);
  logic signed [33:0] x_s [tri_pkg::CORDIC_STEPS+1];
  logic signed [33:0] y_s [tri_pkg::CORDIC_STEPS+1];
  logic signed [33:0] z_s [tri_pkg::CORDIC_STEPS+1];
  logic               v_s [tri_pkg::CORDIC_STEPS+1];
  logic               d_s [tri_pkg::CORDIC_STEPS+1];

  assign x_s[0] = {2'b00, x_in};
  assign y_s[0] = {2'b00, y_in};
  assign z_s[0] = '0;
  assign v_s[0] = vin;
  assign d_s[0] = deg_in;

  for (genvar i = 0; i < tri_pkg::CORDIC_STEPS; i++) begin : g_rot
    logic signed [33:0] xs, ys, at;
    assign xs = x_s[i] >>> i;
    assign ys = y_s[i] >>> i;
    assign at = {3'b000, tri_pkg::atan_q30(i)};
    always_ff @(posedge clk) begin
      v_s[i+1] <= v_s[i];
      d_s[i+1] <= d_s[i];
      if (!y_s[i][33]) begin
        x_s[i+1] <= x_s[i] + ys;
        y_s[i+1] <= y_s[i] - xs;
        z_s[i+1] <= z_s[i] + at;
      end else begin
        x_s[i+1] <= x_s[i] - ys;
        y_s[i+1] <= y_s[i] + xs;
        z_s[i+1] <= z_s[i] - at;
      end
    end
  end

  assign vout    = v_s[tri_pkg::CORDIC_STEPS];
  assign deg_out = d_s[tri_pkg::CORDIC_STEPS];
  always_comb begin
    if (z_s[tri_pkg::CORDIC_STEPS][33]) z_out = '0;
    else if (z_s[tri_pkg::CORDIC_STEPS] > $signed({3'b000, tri_pkg::HALF_PI_Q30}))
      z_out = {1'b0, tri_pkg::HALF_PI_Q30};
    else z_out = z_s[tri_pkg::CORDIC_STEPS][31:0];
  end
endmodule

@@ rtl/triangulation_angle_unit.sv @@
// Triangulation angle unit.
// Write the two camera centres through the config channel (cfg_valid,
// cfg_ready always high, cfg_index 0..5 = A.x A.y A.z B.x B.y B.z, cfg_data).
// Write config only while no point is in flight.
// A point is taken on each edge with start high and busy low; busy is
// always low, so one point enters every cycle.
// Each point yields one result: angle (unsigned, ANGLE_FRAC_BITS fraction
// bits, 0..pi/2 radians) and degenerate, shown for one cycle with done.
// The pipeline has 131 register stages: 3 of squared-norm arithmetic,
// two 32-step square roots side by side, 2 for the denominator and
// dividend alignment, a 30-step divider, 1 for 2^60 - q^2, a 32-step
// square root, a 30-step CORDIC and the output register, one step per
// stage; throughput one point a cycle.
// The receiver cannot stall; results are never held.
// Reset clears the centres to zero and empties the pipeline.
module triangulation_angle_unit #(
  parameter int COORD_WIDTH     = tri_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = tri_pkg::ANGLE_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [COORD_WIDTH-1:0]     point_x,
  input  logic signed [COORD_WIDTH-1:0]     point_y,
  input  logic signed [COORD_WIDTH-1:0]     point_z,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tri_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [COORD_WIDTH-1:0]            cfg_data,
  output logic                              done,
  output logic [ANGLE_FRAC_BITS:0]          angle,
  output logic                              degenerate
);
  localparam int DSH = (COORD_WIDTH > 29) ? COORD_WIDTH - 29 : 0;
  localparam int DW  = COORD_WIDTH + 1;
  localparam int MW  = COORD_WIDTH - DSH;

  logic signed [COORD_WIDTH-1:0] ax, ay, az, bx, by, bz;
  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0; ay <= '0; az <= '0; bx <= '0; by <= '0; bz <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tri_pkg::REG_AX: ax <= cfg_data;
        tri_pkg::REG_AY: ay <= cfg_data;
        tri_pkg::REG_AZ: az <= cfg_data;
        tri_pkg::REG_BX: bx <= cfg_data;
        tri_pkg::REG_BY: by <= cfg_data;
        tri_pkg::REG_BZ: bz <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [MW-1:0] mag(input logic signed [COORD_WIDTH-1:0] p,
                                        input logic signed [COORD_WIDTH-1:0] c);
    logic signed [DW-1:0] d;
    logic [DW-1:0] m;
    d = DW'(p) - DW'(c);
    m = d[DW-1] ? DW'(-d) : DW'(d);
    return MW'(m >> DSH);
  endfunction

  // stage 1: difference magnitudes
  logic v1;
  logic [MW-1:0] m1 [9];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    m1[0] <= mag(point_x, ax); m1[1] <= mag(point_y, ay); m1[2] <= mag(point_z, az);
    m1[3] <= mag(point_x, bx); m1[4] <= mag(point_y, by); m1[5] <= mag(point_z, bz);
    m1[6] <= mag(ax, bx);      m1[7] <= mag(ay, by);      m1[8] <= mag(az, bz);
  end

  // stage 2: squares
  logic v2;
  logic [63:0] sq2 [9];
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    for (int i = 0; i < 9; i++) sq2[i] <= 64'(m1[i]) * 64'(m1[i]);
  end

  // stage 3: sums, numerator, normalizing shift
  logic v3, deg3;
  logic [63:0] r1_3, r2_3, num3;
  logic [4:0] k1_3, k2_3;
  logic [63:0] r1c, r2c, blc;
  logic signed [64:0] nsc;
  // smallest k with r*4^k >= 2^60 is the largest j with r*4^(j-1) < 2^60
  logic [4:0] k1f, k2f;
  always_comb begin
    r1c = sq2[0] + sq2[1] + sq2[2];
    r2c = sq2[3] + sq2[4] + sq2[5];
    blc = sq2[6] + sq2[7] + sq2[8];
    nsc = $signed({1'b0, r1c + r2c}) - $signed({1'b0, blc});
    k1f = '0; k2f = '0;
    for (int j = 1; j <= 30; j++) begin
      if (r1c < (64'd1 << (62 - 2 * j))) k1f = 5'(j);
      if (r2c < (64'd1 << (62 - 2 * j))) k2f = 5'(j);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    deg3 <= (r1c == 0) || (r2c == 0);
    r1_3 <= r1c << {k1f, 1'b0};
    r2_3 <= r2c << {k2f, 1'b0};
    k1_3 <= k1f; k2_3 <= k2f;
    num3 <= nsc[64] ? 64'(-nsc) : nsc[63:0];
  end

  // square roots of the normalized lengths, carrying side data
  logic [63:0] rem_a [tri_pkg::SQRT_STEPS+1], res_a [tri_pkg::SQRT_STEPS+1];
  logic [63:0] rem_b [tri_pkg::SQRT_STEPS+1], res_b [tri_pkg::SQRT_STEPS+1];
  logic [63:0] num_p [tri_pkg::SQRT_STEPS+1];
  logic [5:0]  sh_p  [tri_pkg::SQRT_STEPS+1];
  logic        dg_p  [tri_pkg::SQRT_STEPS+1];
  logic        vs_p  [tri_pkg::SQRT_STEPS+1];
  assign rem_a[0] = r1_3; assign res_a[0] = '0;
  assign rem_b[0] = r2_3; assign res_b[0] = '0;
  assign num_p[0] = num3; assign sh_p[0] = 6'(k1_3) + 6'(k2_3);
  assign dg_p[0] = deg3;  assign vs_p[0] = v3;

  for (genvar i = 0; i < tri_pkg::SQRT_STEPS; i++) begin : g_sq
    tri_sqrt_stage #(.STEP(i)) u_a (.clk, .rem_in(rem_a[i]),
      .res_in(res_a[i]), .rem_out(rem_a[i+1]), .res_out(res_a[i+1]));
    tri_sqrt_stage #(.STEP(i)) u_b (.clk, .rem_in(rem_b[i]),
      .res_in(res_b[i]), .rem_out(rem_b[i+1]), .res_out(res_b[i+1]));
    always_ff @(posedge clk) begin
      if (rst) vs_p[i+1] <= 1'b0;
      else vs_p[i+1] <= vs_p[i];
      num_p[i+1] <= num_p[i];
      sh_p[i+1]  <= sh_p[i];
      dg_p[i+1]  <= dg_p[i];
    end
  end

  // product stage: den = 2*s1*s2 (s < 2^31, 32x32 multiply)
  logic vd, degd, satd;
  logic [63:0] dend, numd;
  logic [5:0] shd;
  logic [31:0] s1w, s2w;
  logic [63:0] prod;
  assign s1w = res_a[tri_pkg::SQRT_STEPS][31:0];
  assign s2w = res_b[tri_pkg::SQRT_STEPS][31:0];
  assign prod = 64'(s1w) * 64'(s2w);
  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else vd <= vs_p[tri_pkg::SQRT_STEPS];
    dend <= prod << 1;
    numd <= num_p[tri_pkg::SQRT_STEPS];
    shd  <= sh_p[tri_pkg::SQRT_STEPS];
    degd <= dg_p[tri_pkg::SQRT_STEPS];
  end
  // saturation test and dividend alignment
  logic ve, dege, sate;
  logic [63:0] dene;
  logic [127:0] reme;
  always_ff @(posedge clk) begin
    if (rst) ve <= 1'b0;
    else ve <= vd;
    dene <= dend;
    dege <= degd;
    sate <= (shd < 6'd63) && (numd > ((dend - 64'd1) >> shd));
    reme <= (shd >= 6'd63) ? 128'd0 : (128'(numd) << shd);
  end
  assign satd = 1'b0;

  // restoring divider, one quotient bit per stage
  logic [127:0] drem [tri_pkg::DIV_STEPS+1];
  logic [30:0]  dq   [tri_pkg::DIV_STEPS+1];
  logic [63:0]  dden [tri_pkg::DIV_STEPS+1];
  logic         dv [tri_pkg::DIV_STEPS+1], ddg [tri_pkg::DIV_STEPS+1];
  logic         dst [tri_pkg::DIV_STEPS+1];
  assign drem[0] = reme; assign dq[0] = '0; assign dden[0] = dene;
  assign dv[0] = ve; assign ddg[0] = dege; assign dst[0] = sate | satd;
  for (genvar i = 0; i < tri_pkg::DIV_STEPS; i++) begin : g_div
    logic [127:0] sh_r;
    assign sh_r = drem[i] << 1;
    always_ff @(posedge clk) begin
      if (rst) dv[i+1] <= 1'b0;
      else dv[i+1] <= dv[i];
      ddg[i+1]  <= ddg[i];
      dst[i+1]  <= dst[i];
      dden[i+1] <= dden[i];
      if (sh_r >= 128'(dden[i])) begin
        drem[i+1] <= sh_r - 128'(dden[i]);
        dq[i+1]   <= {dq[i][29:0], 1'b1};
      end else begin
        drem[i+1] <= sh_r;
        dq[i+1]   <= {dq[i][29:0], 1'b0};
      end
    end
  end

  // q and 2^60 - q^2
  logic vq, dgq;
  logic [30:0] qq;
  logic [63:0] yrad;
  logic [30:0] qc;
  assign qc = dst[tri_pkg::DIV_STEPS] ? 31'h4000_0000 : dq[tri_pkg::DIV_STEPS];
  always_ff @(posedge clk) begin
    if (rst) vq <= 1'b0;
    else vq <= dv[tri_pkg::DIV_STEPS];
    dgq  <= ddg[tri_pkg::DIV_STEPS];
    qq   <= qc;
    yrad <= (64'd1 << 60) - 64'(qc) * 64'(qc);
  end

  logic [63:0] rem_y [tri_pkg::SQRT_STEPS+1], res_y [tri_pkg::SQRT_STEPS+1];
  logic        vyc [tri_pkg::SQRT_STEPS+1];
  logic [30:0] qy [tri_pkg::SQRT_STEPS+1];
  logic        dy [tri_pkg::SQRT_STEPS+1];
  assign rem_y[0] = yrad; assign res_y[0] = '0;
  assign qy[0] = qq; assign dy[0] = dgq; assign vyc[0] = vq;
  for (genvar i = 0; i < tri_pkg::SQRT_STEPS; i++) begin : g_sy
    tri_sqrt_stage #(.STEP(i)) u_y (.clk, .rem_in(rem_y[i]),
      .res_in(res_y[i]), .rem_out(rem_y[i+1]), .res_out(res_y[i+1]));
    always_ff @(posedge clk) begin
      if (rst) vyc[i+1] <= 1'b0;
      else vyc[i+1] <= vyc[i];
      qy[i+1] <= qy[i];
      dy[i+1] <= dy[i];
    end
  end

  logic vc, dgc;
  logic [31:0] zc;
  logic vc_r;
  tri_cordic u_cordic (
    .clk, .vin(vyc[tri_pkg::SQRT_STEPS]),
    .x_in({1'b0, qy[tri_pkg::SQRT_STEPS]}),
    .y_in(res_y[tri_pkg::SQRT_STEPS][31:0]),
    .deg_in(dy[tri_pkg::SQRT_STEPS]),
    .vout(vc), .z_out(zc), .deg_out(dgc)
  );
  // cordic valid chain is unreset; gate with a reset-cleared shadow
  logic [tri_pkg::CORDIC_STEPS-1:0] vsh;
  always_ff @(posedge clk) begin
    if (rst) vsh <= '0;
    else vsh <= {vsh[tri_pkg::CORDIC_STEPS-2:0], vyc[tri_pkg::SQRT_STEPS]};
  end
  assign vc_r = vsh[tri_pkg::CORDIC_STEPS-1] & vc;

  logic [32:0] rnd;
  assign rnd = 33'(zc) + (33'd1 << (29 - ANGLE_FRAC_BITS));
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vc_r;
    degenerate <= dgc;
    angle <= dgc ? '0 : (ANGLE_FRAC_BITS+1)'(rnd >> (30 - ANGLE_FRAC_BITS));
  end
endmodule

@@ rtl/tri_checker.sv @@
module tri_checker #(
  parameter int ANGLE_FRAC_BITS = tri_pkg::ANGLE_FRAC_DEF
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     busy,
  input logic                     cfg_ready,
  input logic                     done,
  input logic [ANGLE_FRAC_BITS:0] angle,
  input logic                     degenerate
);
  a_busy: assert property (@(posedge clk) disable iff (rst) !busy) else $error("busy");
  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready) else $error("cfg");
  a_deg: assert property (@(posedge clk) disable iff (rst)
    done && degenerate |-> angle == '0) else $error("degenerate angle");
  a_rst: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !done) else $error("done after reset");
endmodule

bind triangulation_angle_unit tri_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_chk (
  .clk, .rst, .busy, .cfg_ready, .done, .angle, .degenerate
);

@@ sim/triangulation_angle_unit_tb.sv @@
module triangulation_angle_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = tri_pkg::COORD_WIDTH_DEF;
  localparam int AW = tri_pkg::ANGLE_FRAC_DEF + 1;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [AW-1:0] angle;
    logic          degenerate;
  } ray_angle_t;

  typedef struct {
    bit                     is_cfg;
    tri_pkg::cfg_reg_t      idx;
    logic signed [CW-1:0]   v0, v1, v2;
    bit                     typed;
    ray_angle_t             res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic signed [CW-1:0] point_x = '0, point_y = '0, point_z = '0;
  logic cfg_valid = 1'b0;
  tri_pkg::cfg_reg_t cfg_index = tri_pkg::REG_AX;
  logic [CW-1:0] cfg_data = '0;
  logic busy, cfg_ready, done, degenerate;
  logic [AW-1:0] angle;

  bit cur_typed = 1'b0;
  ray_angle_t cur_res = '0;

  logic signed [CW-1:0] cen_a [3];
  logic signed [CW-1:0] cen_b [3];
  ray_angle_t angle_q [$];
  stim_row_t stim_tab [$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  triangulation_angle_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .angle(angle), .degenerate(degenerate)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint unsigned sq_dist1(logic signed [CW-1:0] a,
                                                logic signed [CW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d) * longint'(d);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic ray_angle_t ray_angle(logic signed [CW-1:0] px,
                                           logic signed [CW-1:0] py,
                                           logic signed [CW-1:0] pz);
    longint unsigned r1, r2, bl, s1, s2, den, num, q, rem, yq, rn;
    longint ns, x, y, z, xs, ys;
    int k1, k2, sh;
    ray_angle_t o;
    r1 = sq_dist1(px, cen_a[0]) + sq_dist1(py, cen_a[1]) + sq_dist1(pz, cen_a[2]);
    r2 = sq_dist1(px, cen_b[0]) + sq_dist1(py, cen_b[1]) + sq_dist1(pz, cen_b[2]);
    bl = sq_dist1(cen_a[0], cen_b[0]) + sq_dist1(cen_a[1], cen_b[1]) +
         sq_dist1(cen_a[2], cen_b[2]);
    if (r1 == 0 || r2 == 0) begin
      o.angle = '0;
      o.degenerate = 1'b1;
      return o;
    end
    // normalize each squared length to at least 2^60 before the root
    rn = r1; k1 = 0;
    while (rn < (64'd1 << 60)) begin rn <<= 2; k1++; end
    s1 = int_sqrt(rn);
    rn = r2; k2 = 0;
    while (rn < (64'd1 << 60)) begin rn <<= 2; k2++; end
    s2 = int_sqrt(rn);
    den = 2 * s1 * s2;
    sh = k1 + k2;
    ns = longint'(r1 + r2) - longint'(bl);
    num = (ns < 0) ? longint'(-ns) : longint'(ns);
    if (sh < 63 && num > ((den - 1) >> sh)) begin
      q = 64'd1 << 30;
    end else begin
      rem = (sh >= 63) ? 0 : (num << sh);
      q = 0;
      for (int i = 0; i < 30; i++) begin
        rem <<= 1;
        q <<= 1;
        if (rem >= den) begin
          rem -= den;
          q |= 1;
        end
      end
    end
    yq = int_sqrt((64'd1 << 60) - q * q);
    x = longint'(q);
    y = longint'(yq);
    z = 0;
    for (int i = 0; i < tri_pkg::CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += longint'(tri_pkg::atan_q30(i));
      end else begin
        x = x - ys; y = y + xs; z -= longint'(tri_pkg::atan_q30(i));
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(tri_pkg::HALF_PI_Q30)) z = longint'(tri_pkg::HALF_PI_Q30);
    o.angle = AW'((z + (64'd1 << (29 - tri_pkg::ANGLE_FRAC_DEF))) >>
                  (30 - tri_pkg::ANGLE_FRAC_DEF));
    o.degenerate = 1'b0;
    return o;
  endfunction

  function automatic void add_expect(ray_angle_t e);
    angle_q = {angle_q, e};
  endfunction

  function automatic void add_row(bit is_cfg, tri_pkg::cfg_reg_t idx,
                                  logic signed [CW-1:0] v0, logic signed [CW-1:0] v1,
                                  logic signed [CW-1:0] v2, bit typed, ray_angle_t res);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.idx = idx;
    row.v0 = v0;
    row.v1 = v1;
    row.v2 = v2;
    row.typed = typed;
    row.res = res;
    stim_tab = {stim_tab, row};
  endfunction

  task automatic report(string what, ray_angle_t want);
    errors++;
    $display("mismatch at cycle %0d: %s got angle=%0d deg=%0b want angle=%0d deg=%0b",
             cycles, what, angle, degenerate, want.angle, want.degenerate);
  endtask

  // result check, transaction capture and config shadow
  always @(posedge clk) begin
    ray_angle_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangulation_angle_unit_tb: errors");
      $finish;
    end else if (!rst) begin
      if (done) begin
        if (angle_q.size() == 0) begin
          report("unexpected result", '0);
        end else begin
          want = angle_q.pop_front();
          if (angle !== want.angle) report("angle", want);
          else if (degenerate !== want.degenerate) report("degenerate", want);
        end
      end
      if (start && !busy)
        add_expect(cur_typed ? cur_res : ray_angle(point_x, point_y, point_z));
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tri_pkg::REG_AX: cen_a[0] = cfg_data;
          tri_pkg::REG_AY: cen_a[1] = cfg_data;
          tri_pkg::REG_AZ: cen_a[2] = cfg_data;
          tri_pkg::REG_BX: cen_b[0] = cfg_data;
          tri_pkg::REG_BY: cen_b[1] = cfg_data;
          tri_pkg::REG_BZ: cen_b[2] = cfg_data;
          default: ;
        endcase
      end
    end
  end

  task automatic write_reg(tri_pkg::cfg_reg_t idx, logic [CW-1:0] val);
    @(negedge clk);
    if (start) start = 1'b0;
    // hold config until the pipeline is empty
    while (angle_q.size() != 0) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            logic signed [CW-1:0] pz, bit typed, ray_angle_t res);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    point_x = px; point_y = py; point_z = pz;
    cur_typed = typed;
    cur_res = res;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(5))
      0: return CMAX;
      1: return CMIN;
      2: return CW'($signed($urandom_range(0, 8191)) - 4096);
      default: return CW'($urandom);
    endcase
  endfunction

  initial begin
    stim_row_t row;
    logic signed [CW-1:0] c [3];
    int pick;
    ray_angle_t on_ctr;
    on_ctr.angle = '0;
    on_ctr.degenerate = 1'b1;
    for (int i = 0; i < 3; i++) begin cen_a[i] = '0; cen_b[i] = '0; end

    // after reset both centers sit at the origin
    add_row(0, tri_pkg::REG_AX, '0, '0, '0, 1, on_ctr);
    add_row(0, tri_pkg::REG_AX, CMAX, CMAX, CMAX, 0, '0);
    add_row(0, tri_pkg::REG_AX, CMIN, CMIN, CMIN, 0, '0);
    add_row(1, tri_pkg::REG_AX, CMIN, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_AY, CMIN, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_AZ, CMIN, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_BX, CMAX, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_BY, CMAX, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_BZ, CMAX, '0, '0, 0, '0);
    add_row(0, tri_pkg::REG_AX, CMIN, CMIN, CMIN, 1, on_ctr);
    add_row(0, tri_pkg::REG_AX, CMAX, CMAX, CMAX, 1, on_ctr);
    add_row(0, tri_pkg::REG_AX, '0, '0, '0, 0, '0);
    add_row(0, tri_pkg::REG_AX, CMAX, CMIN, CMAX, 0, '0);
    add_row(0, tri_pkg::REG_AX, CMIN, CMAX, '0, 0, '0);
    // right angle: centers on the x axis, point on the y axis
    add_row(1, tri_pkg::REG_AX, 24'sd4096, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_AY, '0, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_AZ, '0, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_BX, -24'sd4096, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_BY, '0, '0, '0, 0, '0);
    add_row(1, tri_pkg::REG_BZ, '0, '0, '0, 0, '0);
    add_row(0, tri_pkg::REG_AX, '0, 24'sd4096, '0, 0, '0);
    add_row(0, tri_pkg::REG_AX, 24'sd8192, '0, '0, 0, '0);
    add_row(0, tri_pkg::REG_AX, 24'sd1, 24'sd1, '0, 0, '0);
    add_row(0, tri_pkg::REG_AX, -24'sd4096, '0, '0, 1, on_ctr);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (stim_tab[n]) begin
      row = stim_tab[n];
      if (row.is_cfg) write_reg(row.idx, row.v0);
      else send_point(row.v0, row.v1, row.v2, row.typed, row.res);
    end

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 64 : (ph == 2) ? 20 : 0;
      // coincident centers in the last phase
      for (int r = 0; r < 6; r++) begin
        c[r % 3] = (ph == 3 && r >= 3) ? cen_a[r % 3] : rand_coord();
        write_reg(tri_pkg::cfg_reg_t'(r), c[r % 3]);
      end
      for (int n = 0; n < 325; n++) begin
        if (ph == 0 && n == 160) begin
          @(negedge clk);
          start = 1'b0;
          while (angle_q.size() != 0) @(negedge clk);
        end
        pick = $urandom_range(9);
        c[0] = ($urandom_range(1)) ? cen_a[0] : cen_b[0];
        c[1] = (c[0] == cen_a[0]) ? cen_a[1] : cen_b[1];
        c[2] = (c[0] == cen_a[0]) ? cen_a[2] : cen_b[2];
        if (pick == 0)
          send_point(c[0], c[1], c[2], 0, '0);
        else if (pick <= 2)
          send_point(c[0] + CW'($signed($urandom_range(0, 31)) - 16),
                     c[1] + CW'($signed($urandom_range(0, 31)) - 16),
                     c[2] + CW'($signed($urandom_range(0, 31)) - 16), 0, '0);
        else
          send_point(rand_coord(), rand_coord(), rand_coord(), 0, '0);
      end
    end

    @(negedge clk);
    start = 1'b0;
    while (angle_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("triangulation_angle_unit_tb: clean");
    else $display("triangulation_angle_unit_tb: errors");
    $finish;
  end
endmodule
